// ===== rtl/area_average_downscaler_top_assert.svh =====
// assertion macros for the area averaging downscaler
`ifndef AREA_AVERAGE_DOWNSCALER_TOP_ASSERT_SVH
`define AREA_AVERAGE_DOWNSCALER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AAD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aad assertion failed");
`define AAD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("aad assertion failed");
`else
`define AAD_ASSERT(label, prop)
`define AAD_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/aad_pkg.sv =====
// shared types and constants of the area averaging downscaler
`default_nettype none
package aad_pkg;
  localparam int MAX_OUT_WIDTH = 4096;
  localparam int FRAC_BITS = 16;
  localparam int UNIT = 1 << FRAC_BITS;
  localparam int W_W = FRAC_BITS + 1;
  localparam int CNT_W = 13;
  localparam int POS_W = 29;
  localparam int GAIN_W = 17;
  localparam int ACC_W = 24;
  localparam int SUM_W = 20;
  localparam int ENTRY_W = 3 * SUM_W;
  localparam int COL_AW = $clog2(MAX_OUT_WIDTH);
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 4'd0,
    CFG_SRC_HEIGHT = 4'd1,
    CFG_DST_WIDTH  = 4'd2,
    CFG_DST_HEIGHT = 4'd3,
    CFG_H_STEP     = 4'd4,
    CFG_V_STEP     = 4'd5,
    CFG_H_GAIN     = 4'd6,
    CFG_V_GAIN     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] src_pixel;
    logic        frame_start;
  } src_item_t;

  typedef struct packed {
    logic [23:0] out_pixel;
    logic        line_end;
    logic        frame_end;
  } dst_item_t;

  typedef struct packed {
    logic               rd_en;
    logic [COL_AW-1:0]  rd_addr;
    logic               wr_en;
    logic [COL_AW-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } col_req_t;
endpackage
`default_nettype wire

// ===== rtl/aad_colstore.sv =====
// per-column vertical partial sums, one read and one write port
`default_nettype none
module aad_colstore import aad_pkg::*; (
  input  logic               clk,
  input  col_req_t           req,
  output logic [ENTRY_W-1:0] rd_data
);
  logic [ENTRY_W-1:0] mem [MAX_OUT_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/area_average_downscaler_top.sv =====
// area averaging downscaler: control, datapath and the column sum store
// usage:
// source pixels come in raster order on src_valid/src_ready/src_data; a
// request with frame_start set restarts all position counters first.
// each source request gives zero or one output pixel on dst_valid/dst_ready/
// dst_data, with line_end on the last pixel of an output row and frame_end
// on the last pixel of the frame.
// registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; write them only while the block is idle.
// one source pixel is accepted, then passes five steps that read the column
// store, weigh, normalize and write back; the store's read latency and the
// chain of multipliers with a register after each account for these steps.
// the result of a pixel is written to the output register in the last step.
// the output register lets the next pixel be accepted while a result waits;
// if that pixel also makes a result and the receiver still stalls, the block
// holds in its last step until the output register frees.
// reset (synchronous, rst high) loads the default registers and clears all
// counters and accumulators; the column store needs no clearing since row 0
// of every frame overwrites its entries.
`default_nettype none
module area_average_downscaler_top import aad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  src_item_t             src_data,
  output logic                  dst_valid,
  input  logic                  dst_ready,
  output dst_item_t             dst_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_SPLIT, S_HGAIN, S_VWEIGH, S_VGAIN, S_EMIT} state_t;

  localparam logic [POS_W-1:0] UNIT_P = POS_W'(UNIT);
  localparam logic [W_W-1:0] UNIT_W = W_W'(UNIT);
  localparam logic [CNT_W:0] MAX_W = (CNT_W+1)'(MAX_OUT_WIDTH);
  localparam int HP_W = ACC_W + GAIN_W;
  localparam int VP_W = SUM_W + GAIN_W;

  state_t state;

  logic [CNT_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [POS_W-1:0] h_step, v_step;
  logic [GAIN_W-1:0] h_gain, v_gain;

  logic [CNT_W-1:0] source_column, source_row, output_column, output_row;
  logic [POS_W-1:0] h_position, v_position;
  logic [ACC_W-1:0] acc [3];
  logic [23:0] pix;

  logic last_col_q, last_row_q, vend_q, split_q, col_act_q, row_act_q;
  logic line_end_q, frame_end_q;
  logic [W_W-1:0] wtop_q, wrest_q, rest_q;
  logic [COL_AW-1:0] ox_q;
  logic [7:0] wpart_q [3];
  logic [7:0] rpart_q [3];
  logic [HP_W-1:0] hprod_q [3];
  logic [7:0] vtop_q [3];
  logic [7:0] vrest_q [3];
  logic [VP_W-1:0] vprod_q [3];

  // split step, combinational
  logic [CNT_W:0] dw_c;
  logic last_col_c, last_row_c, col_act_c, row_act_c, line_end_c, frame_end_c;
  logic [POS_W-1:0] hs_c, vs_c, rem_c, vrem_c;
  logic [W_W-1:0] w_c, rest_c, wtop_c, wrest_c;
  logic split_c, vend_c;
  logic [7:0] wpart_c [3];
  logic [7:0] rpart_c [3];

  always_comb begin
    logic [W_W+7:0] pw, pr;
    last_col_c = ({1'b0, source_column} + 1'b1) >= {1'b0, src_width};
    last_row_c = ({1'b0, source_row} + 1'b1) >= {1'b0, src_height};
    dw_c = ({1'b0, dst_width} > MAX_W) ? MAX_W : {1'b0, dst_width};
    col_act_c = {1'b0, output_column} < dw_c;
    row_act_c = output_row < dst_height;
    line_end_c = last_col_c || (({1'b0, output_column} + 1'b1) >= dw_c);
    frame_end_c = line_end_c &&
                  (last_row_c || (({1'b0, output_row} + 1'b1) >= {1'b0, dst_height}));
    hs_c = (h_step < UNIT_P) ? UNIT_P : h_step;
    vs_c = (v_step < UNIT_P) ? UNIT_P : v_step;
    rem_c = (hs_c > h_position) ? hs_c - h_position : '0;
    vrem_c = (vs_c > v_position) ? vs_c - v_position : '0;
    split_c = last_col_c || (rem_c <= UNIT_P);
    w_c = (rem_c < UNIT_P) ? rem_c[W_W-1:0] : UNIT_W;
    rest_c = UNIT_W - w_c;
    wtop_c = (vrem_c < UNIT_P) ? vrem_c[W_W-1:0] : UNIT_W;
    vend_c = last_row_c || (vrem_c <= UNIT_P);
    // vrem is at most one unit whenever the row ends early
    wrest_c = (vend_c && !last_row_c) ? UNIT_W - vrem_c[W_W-1:0] : '0;
    for (int i = 0; i < 3; i++) begin
      pw = pix[8*i +: 8] * w_c;
      pr = pix[8*i +: 8] * rest_c;
      wpart_c[i] = pw[FRAC_BITS +: 8];
      rpart_c[i] = pr[FRAC_BITS +: 8];
    end
  end

  // horizontal gain
  logic [HP_W-1:0] hprod_c [3];
  always_comb begin
    logic [ACC_W:0] s;
    logic [ACC_W-1:0] sc;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, acc[i]} + (ACC_W+1)'(wpart_q[i]);
      sc = s[ACC_W] ? '1 : s[ACC_W-1:0];
      hprod_c[i] = sc * h_gain;
    end
  end

  // horizontal normalize and vertical split
  logic [7:0] vtop_c [3];
  logic [7:0] vrest_c [3];
  always_comb begin
    logic [HP_W-FRAC_BITS-1:0] hn;
    logic [7:0] hr;
    logic [W_W+7:0] pt, pr;
    for (int i = 0; i < 3; i++) begin
      hn = hprod_q[i][HP_W-1:FRAC_BITS];
      hr = (hn > (HP_W-FRAC_BITS)'(255)) ? 8'hff : hn[7:0];
      pt = hr * wtop_q;
      pr = hr * wrest_q;
      vtop_c[i] = pt[FRAC_BITS +: 8];
      vrest_c[i] = pr[FRAC_BITS +: 8];
    end
  end

  // vertical sum, gain and write back
  logic [ENTRY_W-1:0] rd_data;
  logic [VP_W-1:0] vprod_c [3];
  logic [ENTRY_W-1:0] wr_data_c;
  always_comb begin
    logic [SUM_W-1:0] old;
    logic [SUM_W:0] s;
    logic [SUM_W-1:0] sc;
    wr_data_c = '0;
    for (int i = 0; i < 3; i++) begin
      old = (source_row == '0) ? '0 : rd_data[SUM_W*i +: SUM_W];
      s = {1'b0, old} + (SUM_W+1)'(vtop_q[i]);
      sc = s[SUM_W] ? '1 : s[SUM_W-1:0];
      vprod_c[i] = sc * v_gain;
      wr_data_c[SUM_W*i +: SUM_W] = vend_q ? SUM_W'(vrest_q[i]) : sc;
    end
  end

  col_req_t col_req;
  always_comb begin
    col_req.rd_en = (state == S_SPLIT);
    col_req.rd_addr = output_column[COL_AW-1:0];
    col_req.wr_en = (state == S_VGAIN) && col_act_q && split_q && row_act_q;
    col_req.wr_addr = ox_q;
    col_req.wr_data = wr_data_c;
  end

  aad_colstore u_colstore (
    .clk     (clk),
    .req     (col_req),
    .rd_data (rd_data)
  );

  // final normalize
  logic [23:0] out_pix_c;
  logic emit_c, out_free;
  always_comb begin
    logic [VP_W-FRAC_BITS-1:0] vn;
    out_pix_c = '0;
    for (int i = 0; i < 3; i++) begin
      vn = vprod_q[i][VP_W-1:FRAC_BITS];
      out_pix_c[8*i +: 8] = (vn > (VP_W-FRAC_BITS)'(255)) ? 8'hff : vn[7:0];
    end
  end
  assign emit_c = col_act_q && split_q && row_act_q && vend_q;
  assign out_free = !dst_valid || dst_ready;

  assign src_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dst_valid <= 1'b0;
      src_width <= CNT_W'(1920);
      src_height <= CNT_W'(1080);
      dst_width <= CNT_W'(1920);
      dst_height <= CNT_W'(1080);
      h_step <= UNIT_P;
      v_step <= UNIT_P;
      h_gain <= GAIN_W'(UNIT);
      v_gain <= GAIN_W'(UNIT);
      source_column <= '0;
      source_row <= '0;
      output_column <= '0;
      output_row <= '0;
      h_position <= '0;
      v_position <= '0;
      for (int i = 0; i < 3; i++) acc[i] <= '0;
    end else begin
      if ((state == S_EMIT) && emit_c && out_free) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SRC_WIDTH:  src_width <= cfg_data[CNT_W-1:0];
          CFG_SRC_HEIGHT: src_height <= cfg_data[CNT_W-1:0];
          CFG_DST_WIDTH:  dst_width <= cfg_data[CNT_W-1:0];
          CFG_DST_HEIGHT: dst_height <= cfg_data[CNT_W-1:0];
          CFG_H_STEP:     h_step <= cfg_data[POS_W-1:0];
          CFG_V_STEP:     v_step <= cfg_data[POS_W-1:0];
          CFG_H_GAIN:     h_gain <= cfg_data[GAIN_W-1:0];
          CFG_V_GAIN:     v_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (src_valid) begin
            pix <= src_data.src_pixel;
            if (src_data.frame_start) begin
              source_column <= '0;
              source_row <= '0;
              output_column <= '0;
              output_row <= '0;
              h_position <= '0;
              v_position <= '0;
              for (int i = 0; i < 3; i++) acc[i] <= '0;
            end
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          last_col_q <= last_col_c;
          last_row_q <= last_row_c;
          vend_q <= vend_c;
          split_q <= split_c;
          col_act_q <= col_act_c;
          row_act_q <= row_act_c;
          line_end_q <= line_end_c;
          frame_end_q <= frame_end_c;
          wtop_q <= wtop_c;
          wrest_q <= wrest_c;
          rest_q <= rest_c;
          ox_q <= output_column[COL_AW-1:0];
          for (int i = 0; i < 3; i++) begin
            wpart_q[i] <= wpart_c[i];
            rpart_q[i] <= rpart_c[i];
          end
          state <= S_HGAIN;
        end
        S_HGAIN: begin
          for (int i = 0; i < 3; i++) hprod_q[i] <= hprod_c[i];
          state <= S_VWEIGH;
        end
        S_VWEIGH: begin
          for (int i = 0; i < 3; i++) begin
            vtop_q[i] <= vtop_c[i];
            vrest_q[i] <= vrest_c[i];
          end
          state <= S_VGAIN;
        end
        S_VGAIN: begin
          for (int i = 0; i < 3; i++) vprod_q[i] <= vprod_c[i];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_c || out_free) begin
            if (emit_c) begin
              dst_data.out_pixel <= out_pix_c;
              dst_data.line_end <= line_end_q;
              dst_data.frame_end <= frame_end_q;
            end
            // row and frame wrap
            if (last_col_q) begin
              source_column <= '0;
              output_column <= '0;
              h_position <= '0;
              for (int i = 0; i < 3; i++) acc[i] <= '0;
              if (last_row_q) begin
                source_row <= '0;
                output_row <= '0;
                v_position <= '0;
              end else begin
                source_row <= source_row + 1'b1;
                if (vend_q) begin
                  output_row <= output_row + 1'b1;
                  v_position <= POS_W'(wrest_q);
                end else begin
                  v_position <= v_position + UNIT_P;
                end
              end
            end else begin
              source_column <= source_column + 1'b1;
              // horizontal accumulation
              if (col_act_q) begin
                if (!split_q) begin
                  for (int i = 0; i < 3; i++) begin
                    acc[i] <= (({1'b0, acc[i]} + (ACC_W+1)'(pix[8*i +: 8])) >
                               (ACC_W+1)'({ACC_W{1'b1}}))
                              ? '1 : acc[i] + ACC_W'(pix[8*i +: 8]);
                  end
                  h_position <= h_position + UNIT_P;
                end else begin
                  output_column <= output_column + 1'b1;
                  for (int i = 0; i < 3; i++) acc[i] <= ACC_W'(rpart_q[i]);
                  h_position <= POS_W'(rest_q);
                end
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "area_average_downscaler_top_assert.svh"

  `AAD_ASSERT(a_accept_to_split, (src_valid && src_ready) |=> (state == S_SPLIT))
  `AAD_ASSERT(a_write_in_vgain, col_req.wr_en |-> (state == S_VGAIN) && !src_ready)
  `AAD_ASSERT(a_stall_holds, ((state == S_EMIT) && emit_c && dst_valid && !dst_ready) |=> (state == S_EMIT))
  `AAD_ASSERT(a_col_bound, output_column <= CNT_W'(MAX_OUT_WIDTH))

endmodule
`default_nettype wire
